// ===== rtl/core/fifo_replacement_tile_cache_unit_macros.svh =====
// assertion macros for the tile cache unit
// expects aclk and aresetn in the scope of each use
`ifndef FIFO_REPLACEMENT_TILE_CACHE_UNIT_MACROS_SVH
`define FIFO_REPLACEMENT_TILE_CACHE_UNIT_MACROS_SVH

// same-cycle implication
`define FRTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/frtc_pkg.sv =====
// shared types and constants for the tile cache unit
// no dependencies
package frtc_pkg;

    localparam int CACHE_DEPTH_DEF = 64;

    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 5;
    localparam int COORD_W  = 24;
    localparam int HANDLE_W = 16;
    localparam int KEY_W    = LEVEL_W + 2 * COORD_W;
    localparam int CFG_W    = 7;

    localparam int S_DATA_W = 72;
    localparam int S_USER_W = CMD_W;
    localparam int M_DATA_W = 24;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_LOOKUP       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP_BLANK = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== rtl/core/frtc_ctrl.sv =====
// controller state machine for the tile cache unit
// depends on frtc_pkg
module frtc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  frtc_pkg::ctrl_status_t  status,
    output frtc_pkg::ctrl_cmd_t     cmd
);
    import frtc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/frtc_datapath.sv =====
// entry store, ring pointers, key compare and result register
// depends on frtc_pkg and the unit macros header
`include "fifo_replacement_tile_cache_unit_macros.svh"

module frtc_datapath #(
    parameter int CACHE_DEPTH = frtc_pkg::CACHE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [frtc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [frtc_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [frtc_pkg::S_USER_W-1:0]  s_tuser,
    input  frtc_pkg::ctrl_cmd_t            cmd,
    output frtc_pkg::ctrl_status_t         status,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [frtc_pkg::M_DATA_W-1:0]  m_tdata
);
    import frtc_pkg::*;

    localparam int PW = $clog2(CACHE_DEPTH);
    localparam int CW = $clog2(CACHE_DEPTH + 1);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;
    localparam int SW = CW + 1;
    localparam int WW = KEY_W + HANDLE_W;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(CACHE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    logic [WW-1:0]       mem [CACHE_DEPTH];

    logic [CFG_W-1:0]    cap_reg;
    logic [PW-1:0]       oldest_reg;
    logic [PW-1:0]       next_reg;
    logic [CW-1:0]       count_reg;

    logic [CMD_W-1:0]    op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] hin_reg;

    logic [CW-1:0]       idx_reg;
    logic [PW-1:0]       rptr_reg;
    logic                rd_pend_reg;
    logic [WW-1:0]       rdata_reg;
    logic                hit_reg;
    logic [HANDLE_W-1:0] hout_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                match;
    logic                issue;
    logic                ins_cmd;
    logic                do_ins;
    logic                evict;
    logic [HANDLE_W-1:0] wr_handle;
    logic [EW-1:0]       cap_w;
    logic [EW-1:0]       cap_eff;
    logic [SW-1:0]       ring_sum;
    logic [SW-1:0]       ring_wrap;

    assign match = rd_pend_reg && (rdata_reg[WW-1:HANDLE_W] == key_reg);
    assign issue = cmd.scan && (idx_reg < count_reg) && !match && !hit_reg;

    always_comb begin
        case (op_reg)
            CMD_INSERT, CMD_LOOKUP_BLANK: ins_cmd = 1'b1;
            default:                      ins_cmd = 1'b0;
        endcase
    end

    assign do_ins    = cmd.finish && ins_cmd && !hit_reg;
    assign wr_handle = (op_reg == CMD_INSERT) ? hin_reg : '0;

    always_comb begin
        cap_w = EW'(cap_reg);
        if (cap_reg == '0) begin
            cap_eff = EW'(1);
        end else if (cap_w > EW'(CACHE_DEPTH)) begin
            cap_eff = EW'(CACHE_DEPTH);
        end else begin
            cap_eff = cap_w;
        end
    end

    assign evict = EW'(count_reg) >= cap_eff;

    assign status.scan_end = match || hit_reg || (idx_reg == count_reg);
    assign status.out_free = !m_tvalid_reg || m_tready;

    // store
    always_ff @(posedge aclk) begin
        if (do_ins) begin
            mem[next_reg] <= {key_reg, wr_handle};
        end
        if (issue) begin
            rdata_reg <= mem[rptr_reg];
        end
    end

    // configuration and ring state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            oldest_reg <= '0;
            next_reg   <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (do_ins) begin
                next_reg <= ring_next(next_reg);
                if (evict) begin
                    oldest_reg <= ring_next(oldest_reg);
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    // scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            rd_pend_reg <= issue;
            if (cmd.load) begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end else begin
                if (issue) begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (match) begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // item and scan payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser[CMD_W-1:0];
            key_reg  <= {s_tdata[LEVEL_W-1:0],
                         s_tdata[LEVEL_W+COORD_W-1:LEVEL_W],
                         s_tdata[LEVEL_W+2*COORD_W-1:LEVEL_W+COORD_W]};
            hin_reg  <= s_tdata[KEY_W+HANDLE_W-1:KEY_W];
            rptr_reg <= oldest_reg;
            hout_reg <= '0;
        end else begin
            if (issue) begin
                rptr_reg <= ring_next(rptr_reg);
            end
            if (match) begin
                hout_reg <= rdata_reg[HANDLE_W-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {{(M_DATA_W - HANDLE_W - 3){1'b0}},
                            do_ins && evict, do_ins, hout_reg, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    assign ring_sum  = SW'(oldest_reg) + SW'(count_reg);
    assign ring_wrap = (ring_sum >= SW'(CACHE_DEPTH)) ? ring_sum - SW'(CACHE_DEPTH)
                                                       : ring_sum;

    `FRTC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CACHE_DEPTH),
        "entry count above depth")
    `FRTC_ASSERT_NOW(a_ring_span, 1'b1, next_reg == ring_wrap[PW-1:0],
        "ring pointers disagree with entry count")
    `FRTC_ASSERT_NOW(a_issue_in_range, issue, idx_reg < count_reg,
        "read beyond valid entries")
    `FRTC_ASSERT_NOW(a_hit_no_insert, m_tvalid_reg && m_tdata_reg[0],
        !m_tdata_reg[HANDLE_W+1], "insert reported on a hit")
    `FRTC_ASSERT_NEXT(a_evict_keeps_count, do_ins && evict,
        count_reg == $past(count_reg), "eviction changed entry count")

endmodule

// ===== rtl/core/fifo_replacement_tile_cache_unit.sv =====
// top level of the tile cache unit
// depends on frtc_pkg, frtc_ctrl and frtc_datapath
//
// Fully associative tile handle cache keyed by (level, x, y) with
// first-in-first-out replacement of up to CACHE_DEPTH entries.
// Input channel s_*: one transaction per request, command in s_tuser.
// Result channel m_*: exactly one result transaction per request, in order.
// cfg_wr_en/cfg_wr_data set the capacity; write only while the unit is idle.
// Valid entries form one ring segment from the oldest slot, so a request
// scans them through the single read port of the entry memory, one entry
// a cycle, stopping on a hit; a miss scans all valid entries, a hit those
// up to the key. The result is registered in the finish step, and the
// controller then returns to idle, where the next request is taken.
// A result waits in the output register while m_tready is low; the next
// request is still accepted and scanned, and only its final step waits.
// Reset empties the cache and sets the capacity to 64; no clearing pass.
module fifo_replacement_tile_cache_unit #(
    parameter int CACHE_DEPTH = frtc_pkg::CACHE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [frtc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_level[4:0], key_x[28:5], key_y[52:29], handle_in[68:53]
    input  logic [frtc_pkg::S_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [frtc_pkg::S_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit[0], handle_out[16:1], inserted[17], evicted[18]
    output logic [frtc_pkg::M_DATA_W-1:0]  m_tdata
);
    import frtc_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    frtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frtc_datapath #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== test/tb_top.sv =====
// testbench for the fifo replacement tile cache unit
// drives lookup and insert requests through several capacity settings and
// checks every result against a scoreboard prediction of the cache; needs frtc_pkg
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import frtc_pkg::*;

    localparam int DEPTH = CACHE_DEPTH_DEF;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int S_PAD_W = S_DATA_W - KEY_W - HANDLE_W;

    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;
    localparam logic [KEY_W-1:0] KEY_LVL_TOP = {5'd31, 24'h000000, 24'hFFFFFF};
    localparam logic [KEY_W-1:0] KEY_X_TOP = {5'd0, 24'hFFFFFF, 24'h000000};
    localparam logic [KEY_W-1:0] KEY_ALT_A = {5'h15, 24'h555555, 24'hAAAAAA};
    localparam logic [KEY_W-1:0] KEY_ALT_B = {5'h0A, 24'hAAAAAA, 24'h555555};
    localparam logic [KEY_W-1:0] KEY_NEAR = {5'd0, 24'h000000, 24'h000001};
    localparam logic [KEY_W-1:0] KEY_MID = {5'd16, 24'h800000, 24'h800000};

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle;
        logic                inserted;
        logic                evicted;
    } cache_result_t;

    class tile_cache_scoreboard;
        logic [KEY_W-1:0]    slot_key [DEPTH];
        logic [HANDLE_W-1:0] slot_handle [DEPTH];
        bit                  slot_valid [DEPTH];
        int                  oldest;
        int                  next_free;
        int                  fill;
        logic [CFG_W-1:0]    capacity;
        cache_result_t       awaited [$];
        int                  mismatches;
        int                  requests;
        int                  hits;
        int                  inserts;
        int                  evictions;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            oldest = 0;
            next_free = 0;
            fill = 0;
            capacity = CAP_RESET;
            mismatches = 0;
            requests = 0;
            hits = 0;
            inserts = 0;
            evictions = 0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity = value;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                   logic [HANDLE_W-1:0] handle_in);
            cache_result_t res;
            int limit;
            res = '0;
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_valid[i] && slot_key[i] == key) begin
                    res.hit = 1'b1;
                    res.handle = slot_handle[i];
                end
            end
            if (!res.hit && (cmd == CMD_INSERT || cmd == CMD_LOOKUP_BLANK)) begin
                limit = capacity;
                if (limit == 0) limit = 1;
                if (limit > DEPTH) limit = DEPTH;
                if (fill >= limit && fill > 0) begin
                    slot_valid[oldest] = 1'b0;
                    oldest = (oldest == DEPTH - 1) ? 0 : oldest + 1;
                    fill--;
                    res.evicted = 1'b1;
                end
                slot_key[next_free] = key;
                slot_handle[next_free] = (cmd == CMD_INSERT) ? handle_in : '0;
                slot_valid[next_free] = 1'b1;
                next_free = (next_free == DEPTH - 1) ? 0 : next_free + 1;
                fill++;
                res.inserted = 1'b1;
            end
            requests++;
            hits += res.hit;
            inserts += res.inserted;
            evictions += res.evicted;
            awaited.insert(awaited.size(), res);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            cache_result_t got;
            cache_result_t want;
            bit bad;
            got.hit = data[0];
            got.handle = data[16:1];
            got.inserted = data[17];
            got.evicted = data[18];
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: m_tdata %h", data);
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            bad = (got.hit !== want.hit) || (got.handle !== want.handle)
                || (got.inserted !== want.inserted) || (got.evicted !== want.evicted);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at %0t: hit %b/%b handle %h/%h",
                              " inserted %b/%b evicted %b/%b"},
                             $realtime, want.hit, got.hit, want.handle, got.handle,
                             want.inserted, got.inserted, want.evicted, got.evicted);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [S_USER_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;

    tile_cache_scoreboard sb;
    logic [KEY_W-1:0]     key_pool [$];
    bit                   sender_idles;
    bit                   receiver_stalls;
    int                   stall_left;
    int                   stall_roll;
    int                   cycle_count;
    int                   capacity_writes;

    fifo_replacement_tile_cache_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (!receiver_stalls) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 65) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                stall_left = (stall_roll < 92) ? $urandom_range(0, 3) : $urandom_range(8, 40);
            end
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        logic [4:0]  lvl;
        logic [23:0] kx;
        logic [23:0] ky;
        int          roll;
        roll = $urandom_range(0, 9);
        lvl = (roll == 0) ? 5'd0 : (roll == 1) ? 5'd31 : 5'($urandom);
        roll = $urandom_range(0, 9);
        kx = (roll == 0) ? 24'h0 : (roll == 1) ? 24'hFFFFFF : 24'($urandom);
        roll = $urandom_range(0, 9);
        ky = (roll == 0) ? 24'h0 : (roll == 1) ? 24'hFFFFFF : 24'($urandom);
        return {lvl, kx, ky};
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                input logic [HANDLE_W-1:0] handle_in);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (!sender_idles || roll < 60)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{S_PAD_W{1'b0}}, handle_in, key[23:0], key[47:24], key[52:48]};
        s_tuser <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, key, handle_in);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(value);
        capacity_writes++;
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] cap_value, input int n_items);
        int                 limit;
        int                 pool_n;
        int                 roll;
        logic [CMD_W-1:0]   cmd;
        logic [KEY_W-1:0]   key;
        write_capacity(cap_value);
        sender_idles = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
        limit = cap_value;
        if (limit == 0) limit = 1;
        if (limit > DEPTH) limit = DEPTH;
        pool_n = $urandom_range((limit / 2 > 2) ? limit / 2 : 2, limit + 6);
        while (key_pool.size() > pool_n) key_pool.delete(0);
        while (key_pool.size() < pool_n) key_pool.insert(key_pool.size(), random_key());
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                cmd = CMD_LOOKUP;
            else if (roll < 65)
                cmd = CMD_INSERT;
            else if (roll < 90)
                cmd = CMD_LOOKUP_BLANK;
            else
                cmd = CMD_SPARE;
            if ($urandom_range(0, 9) == 0)
                key = random_key();
            else
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_request(cmd, key, 16'($urandom));
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = CAP_RESET;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_LOOKUP;
        m_tready = 1'b0;
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        stall_left = 0;
        cycle_count = 0;
        capacity_writes = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset capacity: misses, hits, blank inserts, present-key insert, spare command
        send_request(CMD_LOOKUP, KEY_ZERO, 16'h0000);
        send_request(CMD_INSERT, KEY_ZERO, 16'hFFFF);
        send_request(CMD_LOOKUP, KEY_ZERO, 16'h0000);
        send_request(CMD_INSERT, KEY_ZERO, 16'h1234);
        send_request(CMD_INSERT, KEY_ONES, 16'h0000);
        send_request(CMD_SPARE, KEY_ONES, 16'hFFFF);
        send_request(CMD_LOOKUP_BLANK, KEY_LVL_TOP, 16'hBEEF);
        send_request(CMD_LOOKUP_BLANK, KEY_LVL_TOP, 16'h0000);
        send_request(CMD_SPARE, KEY_X_TOP, 16'h0000);
        send_request(CMD_INSERT, KEY_X_TOP, 16'hAAAA);
        send_request(CMD_INSERT, KEY_ALT_A, 16'h5555);
        send_request(CMD_LOOKUP, KEY_ALT_A, 16'h0000);

        // capacity below the current fill, then the smallest capacity
        write_capacity(7'd2);
        send_request(CMD_INSERT, KEY_ALT_B, 16'h0001);
        send_request(CMD_LOOKUP, KEY_ZERO, 16'h0000);
        send_request(CMD_LOOKUP_BLANK, KEY_NEAR, 16'h0000);
        send_request(CMD_LOOKUP, KEY_LVL_TOP, 16'h0000);
        send_request(CMD_LOOKUP, KEY_ONES, 16'h0000);
        write_capacity(7'd1);
        send_request(CMD_INSERT, KEY_MID, 16'h8000);
        send_request(CMD_INSERT, KEY_ZERO, 16'h7FFF);
        send_request(CMD_LOOKUP, KEY_ZERO, 16'h0000);
        send_request(CMD_LOOKUP, KEY_MID, 16'h0000);

        run_random_phase(7'd1, 60);
        run_random_phase(7'd0, 60);
        run_random_phase(7'd127, 130);
        run_random_phase(7'd64, 130);
        run_random_phase(7'd3, 60);
        run_random_phase(7'd65, 60);
        run_random_phase(7'd8, 60);
        run_random_phase(7'd2, 50);
        run_random_phase(7'd32, 70);
        run_random_phase(7'($urandom_range(1, 127)), 50);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.awaited.size() != 0) begin
            $display("%0d results never arrived", sb.awaited.size());
            sb.mismatches += sb.awaited.size();
        end
        $display("ran %0d requests over %0d capacity settings, fifo wraparound included",
                 sb.requests, capacity_writes + 1);
        $display("saw %0d hits, %0d inserts, %0d evictions, %0d mismatching results",
                 sb.hits, sb.inserts, sb.evictions, sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
